@@ rtl/ifmt_pkg.sv @@
// shared types, codes and character constants for the integer field formatter
`timescale 1ns / 1ps
package ifmt_pkg;

	// counts and character positions within one field
	localparam int LEN_W = 7;
	localparam logic [LEN_W-1:0] PREC_LIMIT = 7'd60;

	localparam logic [1:0] RADIX_DEC    = 2'd0;
	localparam logic [1:0] RADIX_OCT    = 2'd1;
	localparam logic [1:0] RADIX_HEX    = 2'd2;
	localparam logic [1:0] RADIX_UNUSED = 2'd3;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_A_LO  = 8'h61;
	localparam logic [7:0] CH_A_UP  = 8'h41;

	typedef enum logic [1:0] {
		CV_IDLE,
		CV_DABBLE,
		CV_NORM
	} conv_state_t;

	typedef enum logic [1:0] {
		EM_IDLE,
		EM_PLAN,
		EM_LAYOUT,
		EM_RUN
	} emit_state_t;

	typedef struct packed {
		logic       is_signed;
		logic [1:0] radix_sel;
		logic       upper_case;
		logic [5:0] field_width;
		logic [5:0] min_digits;
		logic       has_precision;
		logic       pad_zero;
		logic       left_justify;
		logic       force_sign;
		logic       space_sign;
		logic       alternate;
	} spec_t;

	typedef struct packed {
		logic             done;
		logic             neg;
		logic [LEN_W-1:0] ndig;
	} conv_res_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] base;
		base = upper ? CH_A_UP : CH_A_LO;
		if (d < 4'd10)
			digit_char = CH_ZERO + {4'b0000, d};
		else
			digit_char = base + {4'b0000, d} - 8'd10;
	endfunction

endpackage

@@ rtl/ifmt_conv.sv @@
// magnitude to digit register: bit-serial binary to bcd, or direct octal and hex split
`timescale 1ns / 1ps
module ifmt_conv #(
	parameter int VALUE_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    go,
	input  logic [VALUE_BITS-1:0]   value,
	input  ifmt_pkg::spec_t         spec,
	input  logic                    dig_shift,
	output ifmt_pkg::conv_res_t     res,
	output logic [3:0]              top_digit
);

	localparam int DEC_DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
	localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
	localparam int NUM_DIGITS = (DEC_DIGITS > OCT_DIGITS) ? DEC_DIGITS : OCT_DIGITS;
	localparam int DIG_BITS   = 4 * NUM_DIGITS;
	localparam int CNT_W      = $clog2(VALUE_BITS + 1);

	ifmt_pkg::conv_state_t state_q, state_d;

	logic [VALUE_BITS-1:0]      mag_q;
	logic [DIG_BITS-1:0]        dig_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [ifmt_pkg::LEN_W-1:0] ndig_q;
	logic                       neg_q;

	logic                  neg_d;
	logic                  dec_d;
	logic                  hex_d;
	logic [VALUE_BITS-1:0] mag_d;
	logic [DIG_BITS-1:0]   mag_ext;
	logic [DIG_BITS-1:0]   oct_grp;
	logic [DIG_BITS-1:0]   adj;
	logic                  norm_shift;

	always_comb begin
		neg_d   = spec.is_signed & value[VALUE_BITS-1];
		mag_d   = neg_d ? (~value + 1'b1) : value;
		dec_d   = spec.is_signed || (spec.radix_sel == ifmt_pkg::RADIX_DEC)
			|| (spec.radix_sel == ifmt_pkg::RADIX_UNUSED);
		hex_d   = !spec.is_signed && (spec.radix_sel == ifmt_pkg::RADIX_HEX);
		mag_ext = DIG_BITS'(mag_d);
		for (int i = 0; i < NUM_DIGITS; i++) begin
			oct_grp[4*i +: 4] = {1'b0, mag_ext[3*i +: 3]};
			// add three to every bcd digit of five or more before the shift
			adj[4*i +: 4] = (dig_q[4*i +: 4] >= 4'd5) ? (dig_q[4*i +: 4] + 4'd3)
				: dig_q[4*i +: 4];
		end
	end

	assign top_digit  = dig_q[DIG_BITS-1 -: 4];
	assign norm_shift = (ndig_q != '0) && (top_digit == 4'd0);

	always_comb begin
		state_d  = state_q;
		res.done = 1'b0;
		res.neg  = neg_q;
		res.ndig = ndig_q;
		unique case (state_q)
			ifmt_pkg::CV_IDLE: begin
				if (go)
					state_d = dec_d ? ifmt_pkg::CV_DABBLE : ifmt_pkg::CV_NORM;
			end
			ifmt_pkg::CV_DABBLE: begin
				if (cnt_q == CNT_W'(1))
					state_d = ifmt_pkg::CV_NORM;
			end
			ifmt_pkg::CV_NORM: begin
				if (!norm_shift) begin
					res.done = 1'b1;
					state_d  = ifmt_pkg::CV_IDLE;
				end
			end
			default: state_d = ifmt_pkg::CV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ifmt_pkg::CV_IDLE;
			cnt_q   <= '0;
			ndig_q  <= '0;
		end else begin
			state_q <= state_d;
			if (go && state_q == ifmt_pkg::CV_IDLE) begin
				cnt_q  <= CNT_W'(VALUE_BITS);
				ndig_q <= ifmt_pkg::LEN_W'(NUM_DIGITS);
			end else if (state_q == ifmt_pkg::CV_DABBLE) begin
				cnt_q <= cnt_q - 1'b1;
			end else if (state_q == ifmt_pkg::CV_NORM && norm_shift) begin
				ndig_q <= ndig_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ifmt_pkg::CV_IDLE: begin
				if (go) begin
					neg_q <= neg_d;
					mag_q <= mag_d;
					if (dec_d)
						dig_q <= '0;
					else if (hex_d)
						dig_q <= mag_ext;
					else
						dig_q <= oct_grp;
				end else if (dig_shift) begin
					dig_q <= {dig_q[DIG_BITS-5:0], 4'd0};
				end
			end
			ifmt_pkg::CV_DABBLE: begin
				dig_q <= {adj[DIG_BITS-2:0], mag_q[VALUE_BITS-1]};
				mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
			end
			ifmt_pkg::CV_NORM: begin
				// drop leading zero digits, one a cycle
				if (norm_shift)
					dig_q <= {dig_q[DIG_BITS-5:0], 4'd0};
			end
			default: begin
			end
		endcase
	end

endmodule

@@ rtl/ifmt_emit.sv @@
// field layout and one-character-per-cycle serialiser
`timescale 1ns / 1ps
module ifmt_emit #(
	parameter int MAX_FIELD_CHARS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ifmt_pkg::spec_t     spec,
	input  ifmt_pkg::conv_res_t res,
	input  logic [3:0]          top_digit,
	output logic                dig_shift,
	output logic                strobe,
	output logic [7:0]          out_char,
	output logic                last_char
);

	localparam int W = ifmt_pkg::LEN_W;

	ifmt_pkg::emit_state_t state_q, state_d;

	logic         neg_q;
	logic [W-1:0] ndig_q;
	logic         sign_q;
	logic [W-1:0] zpad_q;
	logic [1:0]   pfx_q;
	logic [W-1:0] pzero_q;
	logic [W-1:0] text_q;
	logic [W-1:0] lpad_end_q, sign_end_q, zero_end_q, pfx_end_q;
	logic [W-1:0] pzero_end_q, dig_end_q, total_q;
	logic [W-1:0] k_q;

	logic [W-1:0] width_x, prec, pmin, nd, dfin, zpad_d, text_d, npad, lpad, rpad;
	logic [W-1:0] b1, b2, b3, b4, b5, b6, b7;
	logic         sign_d, hex_u, oct_u;
	logic [1:0]   pfx_d;
	logic [7:0]   pad_ch, sign_ch;

	// lengths of the pieces of the field
	always_comb begin
		width_x = {1'b0, spec.field_width};
		prec    = ({1'b0, spec.min_digits} > ifmt_pkg::PREC_LIMIT) ? ifmt_pkg::PREC_LIMIT
			: {1'b0, spec.min_digits};
		pmin    = spec.has_precision ? prec : '0;
		nd      = (ndig_q > pmin) ? ndig_q : pmin;
		dfin    = (nd == '0) ? W'(1) : nd;
		hex_u   = !spec.is_signed && (spec.radix_sel == ifmt_pkg::RADIX_HEX);
		oct_u   = !spec.is_signed && (spec.radix_sel == ifmt_pkg::RADIX_OCT);
		sign_d  = spec.is_signed && (neg_q || spec.force_sign || spec.space_sign);
		// no prefix when the only digit is the zero fallback
		if (spec.alternate && (nd != '0) && hex_u)
			pfx_d = 2'd2;
		else if (spec.alternate && (nd != '0) && oct_u)
			pfx_d = 2'd1;
		else
			pfx_d = 2'd0;
		zpad_d = (spec.is_signed && spec.pad_zero && (width_x > dfin + W'(1)))
			? (width_x - dfin - W'(1)) : '0;
		text_d = W'(sign_d) + zpad_d + W'(pfx_d) + dfin;
	end

	always_comb begin
		npad = (width_x > text_q) ? (width_x - text_q) : '0;
		lpad = spec.left_justify ? '0 : npad;
		rpad = spec.left_justify ? npad : '0;
		b1   = lpad;
		b2   = b1 + W'(sign_q);
		b3   = b2 + zpad_q;
		b4   = b3 + W'(pfx_q);
		b5   = b4 + pzero_q;
		b6   = b5 + ndig_q;
		b7   = b6 + rpad;
	end

	always_comb begin
		pad_ch = spec.pad_zero ? ifmt_pkg::CH_ZERO : ifmt_pkg::CH_SPACE;
		if (neg_q)
			sign_ch = ifmt_pkg::CH_MINUS;
		else if (spec.force_sign)
			sign_ch = ifmt_pkg::CH_PLUS;
		else
			sign_ch = ifmt_pkg::CH_SPACE;
	end

	always_comb begin
		state_d   = state_q;
		strobe    = 1'b0;
		dig_shift = 1'b0;
		out_char  = pad_ch;
		last_char = 1'b0;
		unique case (state_q)
			ifmt_pkg::EM_IDLE: begin
				if (res.done)
					state_d = ifmt_pkg::EM_PLAN;
			end
			ifmt_pkg::EM_PLAN: begin
				state_d = ifmt_pkg::EM_LAYOUT;
			end
			ifmt_pkg::EM_LAYOUT: begin
				state_d = ifmt_pkg::EM_RUN;
			end
			ifmt_pkg::EM_RUN: begin
				strobe = 1'b1;
				priority if (k_q < lpad_end_q) begin
					out_char = pad_ch;
				end else if (k_q < sign_end_q) begin
					out_char = sign_ch;
				end else if (k_q < zero_end_q) begin
					out_char = ifmt_pkg::CH_ZERO;
				end else if (k_q < pfx_end_q) begin
					if (k_q == zero_end_q)
						out_char = ifmt_pkg::CH_ZERO;
					else
						out_char = spec.upper_case ? ifmt_pkg::CH_X_UP : ifmt_pkg::CH_X_LO;
				end else if (k_q < pzero_end_q) begin
					out_char = ifmt_pkg::CH_ZERO;
				end else if (k_q < dig_end_q) begin
					out_char  = ifmt_pkg::digit_char(top_digit, spec.upper_case);
					dig_shift = 1'b1;
				end else begin
					out_char = pad_ch;
				end
				last_char = (k_q == total_q - W'(1)) || (k_q == W'(MAX_FIELD_CHARS - 1));
				if (last_char)
					state_d = ifmt_pkg::EM_IDLE;
			end
			default: state_d = ifmt_pkg::EM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ifmt_pkg::EM_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ifmt_pkg::EM_RUN)
				k_q <= k_q + W'(1);
			else
				k_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ifmt_pkg::EM_IDLE && res.done) begin
			neg_q  <= res.neg;
			ndig_q <= res.ndig;
		end
		if (state_q == ifmt_pkg::EM_PLAN) begin
			sign_q  <= sign_d;
			zpad_q  <= zpad_d;
			pfx_q   <= pfx_d;
			pzero_q <= dfin - ndig_q;
			text_q  <= text_d;
		end
		if (state_q == ifmt_pkg::EM_LAYOUT) begin
			lpad_end_q  <= b1;
			sign_end_q  <= b2;
			zero_end_q  <= b3;
			pfx_end_q   <= b4;
			pzero_end_q <= b5;
			dig_end_q   <= b6;
			total_q     <= b7;
		end
	end

endmodule

@@ rtl/integer_field_formatter.sv @@
// printf-style integer formatter: decimal items run through the bcd shift register, then
// leading-zero removal and the layout states; octal and hex items skip the bcd step. the
// serialiser then sends one character per cycle for up to MAX_FIELD_CHARS characters.
// the bcd shift register (one value bit per cycle) and the serialiser set the rate:
// an item occupies the block until its last character, busy falls after that cycle.
// reset clears busy and both sequencers; results cannot be stalled by the receiver.
`timescale 1ns / 1ps
module integer_field_formatter #(
	parameter int VALUE_BITS      = 32,
	parameter int MAX_FIELD_CHARS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [VALUE_BITS-1:0] value,
	input  logic                  is_signed,
	input  logic [1:0]            radix_sel,
	input  logic                  upper_case,
	input  logic [5:0]            field_width,
	input  logic [5:0]            min_digits,
	input  logic                  has_precision,
	input  logic                  pad_zero,
	input  logic                  left_justify,
	input  logic                  force_sign,
	input  logic                  space_sign,
	input  logic                  alternate,
	output logic                  strobe,
	output logic [7:0]            out_char,
	output logic                  last_char
);

	ifmt_pkg::spec_t     spec_d, spec_q;
	ifmt_pkg::conv_res_t conv_res;
	logic                busy_q;
	logic                accept;
	logic                dig_shift;
	logic [3:0]          top_digit;

	always_comb begin
		spec_d.is_signed     = is_signed;
		spec_d.radix_sel     = radix_sel;
		spec_d.upper_case    = upper_case;
		spec_d.field_width   = field_width;
		spec_d.min_digits    = min_digits;
		spec_d.has_precision = has_precision;
		spec_d.pad_zero      = pad_zero;
		spec_d.left_justify  = left_justify;
		spec_d.force_sign    = force_sign;
		spec_d.space_sign    = space_sign;
		spec_d.alternate     = alternate;
	end

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (strobe && last_char) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			spec_q <= spec_d;
	end

	ifmt_conv #(
		.VALUE_BITS (VALUE_BITS)
	) u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (accept),
		.value     (value),
		.spec      (spec_d),
		.dig_shift (dig_shift),
		.res       (conv_res),
		.top_digit (top_digit)
	);

	ifmt_emit #(
		.MAX_FIELD_CHARS (MAX_FIELD_CHARS)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.spec      (spec_q),
		.res       (conv_res),
		.top_digit (top_digit),
		.dig_shift (dig_shift),
		.strobe    (strobe),
		.out_char  (out_char),
		.last_char (last_char)
	);

endmodule

@@ rtl/ifmt_checker.sv @@
// port-level checks for the integer field formatter, bound to the top level
`timescale 1ns / 1ps
module ifmt_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic strobe,
	input logic last_char
);

	// characters only while an item is in progress
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("character strobed while not busy");

	// in the cycle after an item is taken, busy is high and no character is strobed
	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !strobe))
		else $error("accepted item not held busy or strobed at once");

	// the characters of one field come back to back
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last_char) |=> strobe)
		else $error("gap inside a field");

	// the block frees only after the last character of the field
	a_free_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(strobe && last_char))
		else $error("busy dropped without a last character");

endmodule

bind integer_field_formatter ifmt_checker u_ifmt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.strobe    (strobe),
	.last_char (last_char)
);

@@ verif/integer_field_formatter_tb.sv @@
// self-checking testbench for the integer field formatter: field renderer plus character scoreboard
`timescale 1ns / 1ps
module integer_field_formatter_tb;

	localparam int MAX_CHARS    = 64;
	localparam int WATCHDOG     = 2000;
	localparam int DRAIN_CYCLES = 150;
	localparam int RANDOM_ITEMS = 405;

	// expected character stream, rebuilt from each accepted item
	class field_checker;
		logic [7:0] expected_chars[$];
		logic       expected_last[$];
		int mismatches;
		int items_seen;
		int chars_seen;
		int signed_items;
		int oct_items;
		int hex_items;

		function void note_item(logic [31:0] v, ifmt_pkg::spec_t s);
			logic [7:0] body[$];
			logic [31:0] mag;
			logic [3:0] d;
			logic [7:0] pad_ch;
			int unsigned base;
			int prec;
			int npad;
			bit neg;
			bit alt_ok;
			bit hex;
			items_seen++;
			neg = 0;
			alt_ok = 0;
			hex = 0;
			base = 10;
			prec = (s.min_digits > ifmt_pkg::PREC_LIMIT) ? int'(ifmt_pkg::PREC_LIMIT)
				: int'(s.min_digits);
			if (s.is_signed) begin
				signed_items++;
				neg = v[31];
				// most negative value wraps to 2^31, which is its true magnitude
				mag = neg ? (~v + 32'd1) : v;
			end else begin
				mag = v;
				if (s.radix_sel == ifmt_pkg::RADIX_OCT) begin
					base = 8;
					alt_ok = 1;
					oct_items++;
				end else if (s.radix_sel == ifmt_pkg::RADIX_HEX) begin
					base = 16;
					alt_ok = 1;
					hex = 1;
					hex_items++;
				end
			end
			while (mag != 0) begin
				d = 4'(mag % base);
				if (d < 4'd10)
					body.push_front(ifmt_pkg::CH_ZERO + 8'(d));
				else
					body.push_front((s.upper_case ? ifmt_pkg::CH_A_UP : ifmt_pkg::CH_A_LO)
						+ 8'(d) - 8'd10);
				mag = mag / base;
			end
			if (s.has_precision)
				while (body.size() < prec)
					body.push_front(ifmt_pkg::CH_ZERO);
			if (body.size() == 0) begin
				alt_ok = 0;
				body.push_front(ifmt_pkg::CH_ZERO);
			end
			if (s.is_signed) begin
				if (s.pad_zero) begin
					// one place is kept back for the sign, even when none is printed
					npad = int'(s.field_width) - body.size() - 1;
					while (npad > 0) begin
						body.push_front(ifmt_pkg::CH_ZERO);
						npad--;
					end
				end
				if (neg)
					body.push_front(ifmt_pkg::CH_MINUS);
				else if (s.force_sign)
					body.push_front(ifmt_pkg::CH_PLUS);
				else if (s.space_sign)
					body.push_front(ifmt_pkg::CH_SPACE);
			end else if (alt_ok && s.alternate) begin
				if (hex)
					body.push_front(s.upper_case ? ifmt_pkg::CH_X_UP : ifmt_pkg::CH_X_LO);
				body.push_front(ifmt_pkg::CH_ZERO);
			end
			pad_ch = s.pad_zero ? ifmt_pkg::CH_ZERO : ifmt_pkg::CH_SPACE;
			npad = int'(s.field_width) - body.size();
			while (npad > 0) begin
				if (s.left_justify)
					body.push_back(pad_ch);
				else
					body.push_front(pad_ch);
				npad--;
			end
			while (body.size() > MAX_CHARS)
				void'(body.pop_back());
			foreach (body[i]) begin
				expected_chars.push_back(body[i]);
				expected_last.push_back(i == body.size() - 1);
			end
		endfunction

		function void check_char(logic [7:0] c, logic is_last);
			logic [7:0] exp_c;
			logic exp_l;
			chars_seen++;
			if (expected_chars.size() == 0) begin
				$error("unexpected character: out_char 0x%02h last_char %0b", c, is_last);
				mismatches++;
				return;
			end
			exp_c = expected_chars.pop_front();
			exp_l = expected_last.pop_front();
			if (c !== exp_c) begin
				$error("out_char: expected 0x%02h, got 0x%02h", exp_c, c);
				mismatches++;
			end
			if (is_last !== exp_l) begin
				$error("last_char: expected %0b, got %0b", exp_l, is_last);
				mismatches++;
			end
		endfunction
	endclass

	logic            clk;
	logic            arst_n;
	logic            start;
	logic            busy;
	logic [31:0]     value;
	ifmt_pkg::spec_t cur_spec;
	logic            strobe;
	logic [7:0]      out_char;
	logic            last_char;

	field_checker sb;
	int quiet_cycles;

	integer_field_formatter u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.value        (value),
		.is_signed    (cur_spec.is_signed),
		.radix_sel    (cur_spec.radix_sel),
		.upper_case   (cur_spec.upper_case),
		.field_width  (cur_spec.field_width),
		.min_digits   (cur_spec.min_digits),
		.has_precision(cur_spec.has_precision),
		.pad_zero     (cur_spec.pad_zero),
		.left_justify (cur_spec.left_justify),
		.force_sign   (cur_spec.force_sign),
		.space_sign   (cur_spec.space_sign),
		.alternate    (cur_spec.alternate),
		.strobe       (strobe),
		.out_char     (out_char),
		.last_char    (last_char)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// monitor and progress watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe)
				sb.check_char(out_char, last_char);
			if (start && !busy)
				sb.note_item(value, cur_spec);
			if (strobe || (start && !busy))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG) begin
				$display("timeout: nothing accepted for %0d cycles", WATCHDOG);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(input logic [31:0] v, input ifmt_pkg::spec_t s, input bit may_idle);
		bit taken;
		taken = 0;
		value = v;
		cur_spec = s;
		while (!taken) begin
			start = !(may_idle && ($urandom_range(0, 99) < 12));
			@(posedge clk);
			taken = start && !busy;
			@(negedge clk);
		end
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'($urandom_range(0, 20));
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'h0000_0000;
					1: return 32'hFFFF_FFFF;
					2: return 32'h8000_0000;
					default: return 32'h7FFF_FFFF;
				endcase
			end
			2: return 32'(0 - $urandom_range(1, 999));
			3, 4: return 32'($urandom >> $urandom_range(1, 31));
			default: return 32'($urandom);
		endcase
	endfunction

	function automatic ifmt_pkg::spec_t pick_spec();
		ifmt_pkg::spec_t s;
		s.is_signed     = ($urandom_range(0, 2) == 0);
		s.radix_sel     = ($urandom_range(0, 9) == 0) ? ifmt_pkg::RADIX_UNUSED
			: 2'($urandom_range(0, 2));
		s.upper_case    = 1'($urandom_range(0, 1));
		s.field_width   = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
			: 6'($urandom_range(0, 16));
		s.min_digits    = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
			: 6'($urandom_range(0, 12));
		s.has_precision = 1'($urandom_range(0, 1));
		s.pad_zero      = 1'($urandom_range(0, 1));
		s.left_justify  = 1'($urandom_range(0, 1));
		s.force_sign    = 1'($urandom_range(0, 1));
		s.space_sign    = 1'($urandom_range(0, 1));
		s.alternate     = 1'($urandom_range(0, 1));
		return s;
	endfunction

	initial begin
		ifmt_pkg::spec_t s;
		bit steady;
		sb = new();
		quiet_cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		cur_spec = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes, every conversion and the odd corners of padding
		s = '0; s.is_signed = 1'b1; send_item(32'h0000_0000, s, 0);
		s = '0; s.is_signed = 1'b1; send_item(32'h8000_0000, s, 0);
		s = '0; s.is_signed = 1'b1; s.force_sign = 1'b1; send_item(32'h7FFF_FFFF, s, 0);
		s = '0; s.is_signed = 1'b1; s.space_sign = 1'b1; s.field_width = 6'd10;
		s.pad_zero = 1'b1; send_item(32'd42, s, 0);
		s = '0; s.is_signed = 1'b1; s.field_width = 6'd8; s.pad_zero = 1'b1;
		send_item(32'd7, s, 0);
		s = '0; s.is_signed = 1'b1; s.field_width = 6'd12; s.pad_zero = 1'b1;
		send_item(-32'sd123, s, 0);
		s = '0; s.is_signed = 1'b1; s.radix_sel = ifmt_pkg::RADIX_HEX; s.upper_case = 1'b1;
		s.alternate = 1'b1; send_item(32'd255, s, 0);
		s = '0; s.radix_sel = ifmt_pkg::RADIX_DEC; s.force_sign = 1'b1; s.space_sign = 1'b1;
		send_item(32'hFFFF_FFFF, s, 0);
		s = '0; s.radix_sel = ifmt_pkg::RADIX_HEX; s.upper_case = 1'b1; s.alternate = 1'b1;
		s.field_width = 6'd20; s.pad_zero = 1'b1; send_item(32'hFFFF_FFFF, s, 0);
		s = '0; s.radix_sel = ifmt_pkg::RADIX_HEX; s.alternate = 1'b1;
		send_item(32'hDEAD_BEEF, s, 0);
		s = '0; s.radix_sel = ifmt_pkg::RADIX_OCT; s.alternate = 1'b1; send_item(32'd0, s, 0);
		s = '0; s.radix_sel = ifmt_pkg::RADIX_OCT; s.alternate = 1'b1; s.has_precision = 1'b1;
		s.min_digits = 6'd3; send_item(32'd0, s, 0);
		s = '0; s.radix_sel = ifmt_pkg::RADIX_OCT; s.alternate = 1'b1;
		send_item(32'hFFFF_FFFF, s, 0);
		s = '0; s.radix_sel = ifmt_pkg::RADIX_UNUSED; send_item(32'd1234, s, 0);
		s = '0; s.has_precision = 1'b1; send_item(32'd0, s, 0);
		s = '0; s.left_justify = 1'b1; s.pad_zero = 1'b1; s.field_width = 6'd10;
		send_item(32'd99, s, 0);
		s = '0; s.left_justify = 1'b1; s.field_width = 6'd63; send_item(32'd5, s, 0);
		s = '0; s.field_width = 6'd63; send_item(32'd5, s, 0);
		s = '0; s.radix_sel = ifmt_pkg::RADIX_HEX; s.alternate = 1'b1; s.has_precision = 1'b1;
		s.min_digits = 6'd63; s.field_width = 6'd63; send_item(32'hABC, s, 0);
		s = '0; s.is_signed = 1'b1; s.has_precision = 1'b1; s.min_digits = 6'd60;
		s.field_width = 6'd63; s.pad_zero = 1'b1; send_item(32'h8000_0001, s, 0);
		s = '0; s.is_signed = 1'b1; s.has_precision = 1'b1; s.min_digits = 6'd5;
		s.field_width = 6'd3; send_item(-32'sd9, s, 0);
		s = '0; s.radix_sel = ifmt_pkg::RADIX_HEX; s.has_precision = 1'b1; s.min_digits = 6'd4;
		s.left_justify = 1'b1; s.field_width = 6'd9; send_item(32'h1F, s, 0);
		s = '0; s.radix_sel = ifmt_pkg::RADIX_OCT; s.field_width = 6'd5; send_item(32'd8, s, 0);

		// random part, with a stretch where the sender never pauses
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			steady = (i >= 150) && (i < 230);
			send_item(pick_value(), pick_spec(), !steady);
		end
		start = 1'b0;

		while (sb.expected_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d items formatted, %0d characters checked, %0d mismatches",
			sb.items_seen, sb.chars_seen, sb.mismatches);
		$display("conversions: %0d signed decimal, %0d octal, %0d hex, rest unsigned decimal",
			sb.signed_items, sb.oct_items, sb.hex_items);
		if (sb.mismatches == 0 && sb.expected_chars.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/ifmt_pkg.sv
rtl/ifmt_conv.sv
rtl/ifmt_emit.sv
rtl/integer_field_formatter.sv
rtl/ifmt_checker.sv
verif/integer_field_formatter_tb.sv
